[rtl/damped_pendulum_step_assert.svh]
// ----------------------------------------------------------------------------
// damped_pendulum_step_assert.svh
// Assertion macros for the pendulum stepper checker.
// ----------------------------------------------------------------------------
`ifndef DAMPED_PENDULUM_STEP_ASSERT_SVH
`define DAMPED_PENDULUM_STEP_ASSERT_SVH

// same-cycle implication
`define DPS_ASSERT_NOW(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("pendulum check failed");

// next-cycle implication
`define DPS_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("pendulum check failed");

`endif

[rtl/dps_pkg.sv]
// ----------------------------------------------------------------------------
// dps_pkg
// Types, constants and tables for the damped pendulum stepper.
// ----------------------------------------------------------------------------
package dps_pkg;

	localparam int TRIG_ITERATIONS = 16;
	localparam int NITER = (TRIG_ITERATIONS < 24) ? TRIG_ITERATIONS : 24;

	localparam logic [1:0] OP_TICK    = 2'd0;
	localparam logic [1:0] OP_PRESS   = 2'd1;
	localparam logic [1:0] OP_RELEASE = 2'd2;

	localparam logic [2:0] REG_ACCEL_GAIN  = 3'd0;
	localparam logic [2:0] REG_DAMPING     = 3'd1;
	localparam logic [2:0] REG_ARM_LENGTH  = 3'd2;
	localparam logic [2:0] REG_BALL_RADIUS = 3'd3;
	localparam logic [2:0] REG_PIVOT_X     = 3'd4;
	localparam logic [2:0] REG_PIVOT_Y     = 3'd5;

	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic [31:0] ANGLE_RESET   = 32'h2000_0000;
	localparam logic [31:0] QUARTER_TURN  = 32'h4000_0000;
	localparam logic [31:0] HALF_TURN     = 32'h8000_0000;

	typedef logic signed [33:0] cord_t;

	function automatic logic [31:0] atan_lut(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0: r = 32'h20000000;
			5'd1: r = 32'h12E4051E;
			5'd2: r = 32'h09FB385B;
			5'd3: r = 32'h051111D4;
			5'd4: r = 32'h028B0D43;
			5'd5: r = 32'h0145D7E1;
			5'd6: r = 32'h00A2F61E;
			5'd7: r = 32'h00517C55;
			5'd8: r = 32'h0028BE53;
			5'd9: r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

	// round to Q1.15 and saturate
	function automatic logic signed [15:0] to_q15(input cord_t v);
		cord_t r;
		r = (v + 34'sd16384) >>> 15;
		if (r > 34'sd32767)
			return 16'sh7FFF;
		else if (r < -34'sd32768)
			return 16'sh8000;
		else
			return r[15:0];
	endfunction

endpackage

[rtl/damped_pendulum_step.sv]
// Steps: a free-running tick runs CORDIC sin/cos, the velocity and angle update, CORDIC again
// and the bob position; a dragged tick runs a CORDIC arctangent instead of the physics (not on
// the pivot); press runs the grab test; release and unused op go straight to the output.
// One item at a time; the shared CORDIC add/shift unit and one multiplier are reused across the steps.
// A finished result sits in the output register while the next item is taken.
// arst_n clears state, registers to reset values and valid flags asynchronously.
// ----------------------------------------------------------------------------
// damped_pendulum_step
// Fixed-point damped pendulum driven by frame ticks and mouse press/release.
// ----------------------------------------------------------------------------
module damped_pendulum_step (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // mouse_x[11:0], mouse_y[23:12]
	input  logic [1:0]  s_tuser,   // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // angle_out[31:0], bob_x[45:32], bob_y[59:46],
	                               // is_dragging[60], zero fill
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [23:0] cfg_wdata
);
	import dps_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_CORD = 4'd1;
	localparam logic [3:0] ST_SCQ  = 4'd2;
	localparam logic [3:0] ST_MG   = 4'd3;
	localparam logic [3:0] ST_MV   = 4'd4;
	localparam logic [3:0] ST_MD   = 4'd5;
	localparam logic [3:0] ST_AN   = 4'd6;
	localparam logic [3:0] ST_MBX  = 4'd7;
	localparam logic [3:0] ST_MBY  = 4'd8;
	localparam logic [3:0] ST_MBE  = 4'd9;
	localparam logic [3:0] ST_PX   = 4'd10;
	localparam logic [3:0] ST_PY   = 4'd11;
	localparam logic [3:0] ST_PC   = 4'd12;
	localparam logic [3:0] ST_DONE = 4'd13;
	localparam logic [3:0] ST_ATE  = 4'd14;

	logic [3:0]  st_q;
	logic [23:0] gain_q;
	logic [15:0] damp_q;
	logic [9:0]  arm_q;
	logic [7:0]  rad_q;
	logic [11:0] pvx_q, pvy_q;

	logic [31:0]        angle_q, vel_q, vsum_q;
	logic               drag_q;
	logic signed [13:0] bx_q, by_q;

	cord_t       x_q, y_q, z_q;
	logic        atan_q, phys_q;
	logic [4:0]  cnt_q;
	logic [1:0]  quad_q;
	logic signed [15:0] s_q, c_q;
	logic [11:0] mx_q, my_q;
	logic [30:0] sq_q;

	logic signed [31:0] mul_a;
	logic signed [24:0] mul_b;
	logic signed [56:0] prod_s1;

	logic        out_v_q;
	logic [63:0] out_q;

	// datapath helpers
	cord_t xs, ys, zt, sraw, craw, rnd;
	logic  up;
	logic signed [12:0] ax, ay;
	logic signed [14:0] dx, dy;
	logic signed [56:0] pshr15, pshr16;
	logic [31:0] bx_ext, by_ext;

	assign xs = x_q >>> cnt_q;
	assign ys = y_q >>> cnt_q;
	assign zt = {2'b00, atan_lut(cnt_q)};
	assign up = atan_q ? !(y_q > 34'sd0) : (z_q >= 34'sd0);

	assign ay = $signed({1'b0, s_tdata[23:12]}) - $signed({1'b0, pvy_q});
	assign ax = $signed({1'b0, pvx_q}) - $signed({1'b0, s_tdata[11:0]});
	assign dx = 15'(bx_q) - $signed({3'b000, mx_q});
	assign dy = 15'(by_q) - $signed({3'b000, my_q});

	assign pshr15 = prod_s1 >>> 15;
	assign pshr16 = prod_s1 >>> 16;
	assign rnd    = 34'(prod_s1 + 57'sd16384) >>> 15;
	assign bx_ext = 32'(rnd);
	assign by_ext = 32'(rnd);

	always_comb begin
		case (quad_q)
			2'd0: begin sraw = y_q;  craw = x_q;  end
			2'd1: begin sraw = x_q;  craw = -y_q; end
			2'd2: begin sraw = -y_q; craw = -x_q; end
			default: begin sraw = -x_q; craw = y_q; end
		endcase
	end

	always_comb begin
		case (st_q)
			ST_MG: begin
				mul_a = 32'(s_q);
				mul_b = $signed({1'b0, gain_q});
			end
			ST_MD: begin
				mul_a = $signed(vsum_q);
				mul_b = $signed({9'd0, damp_q});
			end
			ST_MBX: begin
				mul_a = 32'(s_q);
				mul_b = $signed({15'd0, arm_q});
			end
			ST_MBY: begin
				mul_a = 32'(c_q);
				mul_b = $signed({15'd0, arm_q});
			end
			ST_PX: begin
				mul_a = 32'(dx);
				mul_b = 25'(dx);
			end
			ST_PY: begin
				mul_a = 32'(dy);
				mul_b = 25'(dy);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s1 <= 57'(mul_a) * 57'(mul_b);
	end

	assign s_tready = (st_q == ST_IDLE);
	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= 24'd1562500;
			damp_q <= 16'd65208;
			arm_q  <= 10'd175;
			rad_q  <= 8'd48;
			pvx_q  <= 12'd320;
			pvy_q  <= 12'd0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_ACCEL_GAIN:  gain_q <= cfg_wdata;
				REG_DAMPING:     damp_q <= cfg_wdata[15:0];
				REG_ARM_LENGTH:  arm_q  <= cfg_wdata[9:0];
				REG_BALL_RADIUS: rad_q  <= cfg_wdata[7:0];
				REG_PIVOT_X:     pvx_q  <= cfg_wdata[11:0];
				REG_PIVOT_Y:     pvy_q  <= cfg_wdata[11:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			angle_q <= ANGLE_RESET;
			vel_q   <= '0;
			drag_q  <= 1'b0;
			bx_q    <= '0;
			by_q    <= '0;
			out_v_q <= 1'b0;
			cnt_q   <= '0;
			atan_q  <= 1'b0;
			phys_q  <= 1'b0;
		end else begin
			if (m_tvalid && m_tready && st_q != ST_DONE)
				out_v_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						mx_q <= s_tdata[11:0];
						my_q <= s_tdata[23:12];
						case (s_tuser)
							OP_TICK: begin
								cnt_q <= '0;
								if (!drag_q) begin
									atan_q <= 1'b0;
									phys_q <= 1'b1;
									x_q    <= CORDIC_GAIN;
									y_q    <= '0;
									z_q    <= {4'd0, angle_q[29:0]};
									quad_q <= angle_q[31:30];
									st_q   <= ST_CORD;
								end else if (ax == 13'sd0 && ay == 13'sd0) begin
									angle_q <= 32'd0 - QUARTER_TURN;
									phys_q  <= 1'b0;
									x_q     <= CORDIC_GAIN;
									y_q     <= '0;
									z_q     <= {4'd0, 30'(32'd0 - QUARTER_TURN)};
									quad_q  <= 2'(HALF_TURN >> 30) + 2'd1;
									atan_q  <= 1'b0;
									st_q    <= ST_CORD;
								end else begin
									atan_q <= 1'b1;
									if (ax < 13'sd0) begin
										x_q <= 34'(-ax) <<< 16;
										y_q <= 34'(-ay) <<< 16;
										z_q <= {2'b00, HALF_TURN};
									end else begin
										x_q <= 34'(ax) <<< 16;
										y_q <= 34'(ay) <<< 16;
										z_q <= '0;
									end
									st_q <= ST_CORD;
								end
							end
							OP_PRESS: st_q <= ST_PX;
							OP_RELEASE: begin
								vel_q  <= '0;
								drag_q <= 1'b0;
								st_q   <= ST_DONE;
							end
							default: st_q <= ST_DONE;
						endcase
					end
				end
				ST_CORD: begin
					if (up) begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						z_q <= z_q - zt;
					end else begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						z_q <= z_q + zt;
					end
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(NITER - 1))
						st_q <= atan_q ? ST_ATE : ST_SCQ;
				end
				ST_ATE: begin
					angle_q <= z_q[31:0] - QUARTER_TURN;
					atan_q  <= 1'b0;
					phys_q  <= 1'b0;
					cnt_q   <= '0;
					x_q     <= CORDIC_GAIN;
					y_q     <= '0;
					z_q     <= {4'd0, 30'(z_q[31:0] - QUARTER_TURN)};
					quad_q  <= 2'((z_q[31:0] - QUARTER_TURN) >> 30);
					st_q    <= ST_CORD;
				end
				ST_SCQ: begin
					s_q  <= to_q15(sraw);
					c_q  <= to_q15(craw);
					st_q <= phys_q ? ST_MG : ST_MBX;
				end
				ST_MG: st_q <= ST_MV;
				ST_MV: begin
					vsum_q <= vel_q - pshr15[31:0];
					st_q   <= ST_MD;
				end
				ST_MD: st_q <= ST_AN;
				ST_AN: begin
					vel_q   <= pshr16[31:0];
					angle_q <= angle_q + pshr16[31:0];
					x_q     <= CORDIC_GAIN;
					y_q     <= '0;
					z_q     <= {4'd0, 30'(angle_q + pshr16[31:0])};
					quad_q  <= 2'((angle_q + pshr16[31:0]) >> 30);
					cnt_q   <= '0;
					phys_q  <= 1'b0;
					st_q    <= ST_CORD;
				end
				ST_MBX: st_q <= ST_MBY;
				ST_MBY: begin
					bx_q <= 14'({20'd0, pvx_q} + bx_ext);
					st_q <= ST_MBE;
				end
				ST_MBE: begin
					by_q <= 14'({20'd0, pvy_q} + by_ext);
					st_q <= ST_DONE;
				end
				ST_PX: st_q <= ST_PY;
				ST_PY: begin
					sq_q <= prod_s1[30:0];
					st_q <= ST_PC;
				end
				ST_PC: begin
					if ({1'b0, sq_q} + {1'b0, prod_s1[30:0]} < {16'd0, 16'(rad_q) * 16'(rad_q)})
						drag_q <= 1'b1;
					st_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_v_q || m_tready) begin
						out_v_q <= 1'b1;
						out_q   <= {3'b000, drag_q, by_q, bx_q, angle_q};
						st_q    <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[rtl/dps_checker.sv]
`include "damped_pendulum_step_assert.svh"
// ----------------------------------------------------------------------------
// dps_checker
// Port-level checks for the pendulum stepper, bound to the top level.
// ----------------------------------------------------------------------------
module dps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata
);
	// one item in flight: busy right after a transfer
	`DPS_ASSERT_NEXT(a_busy_after_in, clk, arst_n, s_tvalid && s_tready, !s_tready)
	// idle with nothing offered stays idle
	`DPS_ASSERT_NEXT(a_idle_holds, clk, arst_n, s_tready && !s_tvalid, s_tready)
	`DPS_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`DPS_ASSERT_NEXT(a_out_stable, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata))

endmodule

bind damped_pendulum_step dps_checker u_dps_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata)
);

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pendulum stepper: random frame ticks, presses
// and releases with random stalls, predicted in fixed point and compared.
// ----------------------------------------------------------------------------
module tb_top;
	import dps_pkg::*;

	typedef struct packed {
		logic [1:0]  op;
		logic [11:0] mx;
		logic [11:0] my;
	} event_t;

	typedef struct packed {
		logic        drag;
		logic [13:0] by;
		logic [13:0] bx;
		logic [31:0] ang;
	} pose_t;

	logic clk, arst_n;
	logic s_tvalid, s_tready, m_tvalid, m_tready;
	logic [23:0] s_tdata;
	logic [1:0] s_tuser;
	logic [63:0] m_tdata;
	logic cfg_we;
	logic [2:0] cfg_addr;
	logic [23:0] cfg_wdata;

	damped_pendulum_step DUT (.*);

	event_t pending_q[$];
	pose_t pose_q[$];
	int errors = 0;
	longint cycles = 0;
	bit hold_send = 0;
	int rdy_gap = 0;

	// predictor state
	longint gain, damp, arm, rad, px, py;
	logic [31:0] p_ang, p_vel;
	bit p_drag;
	longint p_bx, p_by;

	function automatic longint floor_shr(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint q15(longint v);
		longint r;
		r = floor_shr(v + 16384, 15);
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return r;
	endfunction

	function automatic void sin_cos(input logic [31:0] a, output longint s, output longint c);
		longint x, y, z, nx, ny;
		x = 652032874; y = 0; z = a[29:0];
		for (int i = 0; i < NITER; i++) begin
			if (z >= 0) begin
				nx = x - floor_shr(y, i); ny = y + floor_shr(x, i); z -= atan_lut(i);
			end else begin
				nx = x + floor_shr(y, i); ny = y - floor_shr(x, i); z += atan_lut(i);
			end
			x = nx; y = ny;
		end
		case (a[31:30])
			2'd0: begin s = y; c = x; end
			2'd1: begin s = x; c = -y; end
			2'd2: begin s = -y; c = -x; end
			default: begin s = -x; c = y; end
		endcase
		s = q15(s); c = q15(c);
	endfunction

	function automatic logic [31:0] bearing(longint y, longint x);
		logic [31:0] z;
		longint nx, ny;
		z = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin x = -x; y = -y; z = HALF_TURN; end
		x *= 65536; y *= 65536;
		for (int i = 0; i < NITER; i++) begin
			if (y > 0) begin
				nx = x + floor_shr(y, i); ny = y - floor_shr(x, i); z += atan_lut(i);
			end else begin
				nx = x - floor_shr(y, i); ny = y + floor_shr(x, i); z -= atan_lut(i);
			end
			x = nx; y = ny;
		end
		return z;
	endfunction

	function automatic pose_t advance(event_t e);
		longint s, c, acc, v, dx, dy;
		logic [31:0] w;
		pose_t r;
		if (e.op == OP_TICK) begin
			if (!p_drag) begin
				sin_cos(p_ang, s, c);
				acc = -floor_shr(gain * s, 15);
				w = 32'(longint'($signed(p_vel)) + acc);
				v = floor_shr(longint'($signed(w)) * damp, 16);
				p_vel = v[31:0];
				p_ang += p_vel;
			end else
				p_ang = bearing(longint'(e.my) - py, px - longint'(e.mx)) - QUARTER_TURN;
			sin_cos(p_ang, s, c);
			p_bx = px + floor_shr(arm * s + 16384, 15);
			p_by = py + floor_shr(arm * c + 16384, 15);
		end else if (e.op == OP_PRESS) begin
			dx = p_bx - e.mx; dy = p_by - e.my;
			if (dx * dx + dy * dy < rad * rad) p_drag = 1;
		end else if (e.op == OP_RELEASE) begin
			p_vel = 0; p_drag = 0;
		end
		r.ang = p_ang; r.bx = p_bx[13:0]; r.by = p_by[13:0]; r.drag = p_drag;
		return r;
	endfunction

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 2_000_000) begin
			$display("damped_pendulum_step verification failed");
			$finish;
		end
	end

	// driver
	always @(negedge clk) begin
		if (s_tvalid && !s_tready) begin
		end else if (pending_q.size() > 0 && !hold_send && $urandom_range(0, 9) < 7) begin
			s_tvalid <= 1;
			s_tuser <= pending_q[0].op;
			s_tdata <= {pending_q[0].my, pending_q[0].mx};
		end else
			s_tvalid <= 0;
		if (rdy_gap > 0) begin
			rdy_gap--;
			m_tready <= 0;
		end else if ($urandom_range(0, 149) == 0) begin
			rdy_gap = $urandom_range(20, 200);
			m_tready <= 0;
		end else
			m_tready <= ($urandom_range(0, 3) != 0);
	end

	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			pose_q.push_back(advance(pending_q.pop_front()));
			s_tvalid <= 0;
		end
	end

	// monitor
	always @(posedge clk) begin
		pose_t got, want;
		if (m_tvalid && m_tready) begin
			got = m_tdata[60:0];
			if (pose_q.size() == 0) begin
				errors++;
				$display("%t unexpected transfer %h", $time, m_tdata);
			end else begin
				want = pose_q.pop_front();
				if (got.ang !== want.ang) begin
					errors++;
					$display("%t angle exp %h got %h", $time, want.ang, got.ang);
				end
				if (got.bx !== want.bx) begin
					errors++;
					$display("%t bob_x exp %h got %h", $time, want.bx, got.bx);
				end
				if (got.by !== want.by) begin
					errors++;
					$display("%t bob_y exp %h got %h", $time, want.by, got.by);
				end
				if (got.drag !== want.drag) begin
					errors++;
					$display("%t drag exp %b got %b", $time, want.drag, got.drag);
				end
			end
		end
	end

	task automatic drain();
		while (pending_q.size() > 0 || pose_q.size() > 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [23:0] val);
		@(negedge clk);
		cfg_we <= 1; cfg_addr <= idx; cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 0;
		case (idx)
			REG_ACCEL_GAIN: gain = val;
			REG_DAMPING: damp = val[15:0];
			REG_ARM_LENGTH: arm = val[9:0];
			REG_BALL_RADIUS: rad = val[7:0];
			REG_PIVOT_X: px = val[11:0];
			default: py = val[11:0];
		endcase
	endtask

	task automatic push(logic [1:0] op, logic [11:0] x, logic [11:0] y);
		event_t e;
		e.op = op; e.mx = x; e.my = y;
		pending_q.push_back(e);
	endtask

	// a grab near the bob, some dragged ticks, then a release
	task automatic drag_burst();
		longint bx, by;
		bx = p_bx; by = p_by;
		foreach (pose_q[i]) begin bx = $signed(pose_q[i].bx); by = $signed(pose_q[i].by); end
		push(OP_PRESS, 12'(bx + $urandom_range(0, 20) - 10),
			12'(by + $urandom_range(0, 20) - 10));
		repeat ($urandom_range(1, 8)) push(OP_TICK, 12'($urandom), 12'($urandom));
		push(OP_RELEASE, 12'($urandom), 12'($urandom));
	endtask

	task automatic random_phase(int n);
		int k;
		for (k = 0; k < n; k++) begin
			case ($urandom_range(0, 9))
				0: push(2'd3, 12'($urandom), 12'($urandom));
				1, 2: begin drain(); drag_burst(); end
				3: push(OP_PRESS, 12'($urandom), 12'($urandom));
				4: push(OP_RELEASE, 12'($urandom), 12'($urandom));
				default: push(OP_TICK, 12'($urandom), 12'($urandom));
			endcase
			while (pending_q.size() > 4) @(posedge clk);
			if ($urandom_range(0, 30) == 0) repeat ($urandom_range(20, 300)) @(posedge clk);
		end
	endtask

	initial begin
		arst_n = 0; s_tvalid = 0; s_tdata = 0; s_tuser = 0; m_tready = 0;
		cfg_we = 0; cfg_addr = 0; cfg_wdata = 0;
		gain = 1562500; damp = 65208; arm = 175; rad = 48; px = 320; py = 0;
		p_ang = ANGLE_RESET; p_vel = 0; p_drag = 0; p_bx = 0; p_by = 0;
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1;

		// directed: press before any tick, odd cases, pivot on mouse
		push(OP_PRESS, 12'd0, 12'd0);
		push(OP_RELEASE, 12'd0, 12'd0);
		push(2'd3, 12'hFFF, 12'hFFF);
		repeat (4) push(OP_TICK, 12'hFFF, 12'h000);
		drain();
		drag_burst();
		push(OP_PRESS, 12'hFFF, 12'hFFF);
		drain();
		drag_burst();
		push(OP_TICK, 12'd320, 12'd0);
		drain();
		hold_send = 1;
		push(OP_PRESS, p_bx[11:0], p_by[11:0]);
		push(OP_TICK, 12'd320, 12'd0);
		push(OP_TICK, 12'd0, 12'hFFF);
		push(OP_TICK, 12'hFFF, 12'd0);
		push(OP_RELEASE, 12'd0, 12'd0);
		hold_send = 0;
		drain();

		random_phase(140);
		drain();
		write_reg(REG_ACCEL_GAIN, 24'hFFFFFF);
		write_reg(REG_DAMPING, 24'h00FFFF);
		write_reg(REG_ARM_LENGTH, 24'h0003FF);
		write_reg(REG_BALL_RADIUS, 24'h0000FF);
		write_reg(REG_PIVOT_X, 24'h000FFF);
		write_reg(REG_PIVOT_Y, 24'h000FFF);
		random_phase(140);
		drain();
		write_reg(REG_ACCEL_GAIN, 24'd0);
		write_reg(REG_DAMPING, 24'd0);
		write_reg(REG_ARM_LENGTH, 24'd0);
		write_reg(REG_BALL_RADIUS, 24'd0);
		write_reg(REG_PIVOT_X, 24'd0);
		write_reg(REG_PIVOT_Y, 24'd0);
		random_phase(70);
		drain();
		write_reg(REG_ARM_LENGTH, 24'h0003FF);
		write_reg(REG_BALL_RADIUS, 24'h0000FF);
		random_phase(50);
		drain();
		write_reg(REG_ACCEL_GAIN, 24'($urandom_range(0, 24'hFFFFFF)));
		write_reg(REG_DAMPING, 24'($urandom_range(60000, 65535)));
		write_reg(REG_ARM_LENGTH, 24'($urandom_range(50, 1023)));
		write_reg(REG_BALL_RADIUS, 24'($urandom_range(20, 255)));
		write_reg(REG_PIVOT_X, 24'($urandom_range(0, 4095)));
		write_reg(REG_PIVOT_Y, 24'($urandom_range(0, 4095)));
		random_phase(170);
		drain();

		if (errors == 0)
			$display("damped_pendulum_step verification clean");
		else
			$display("damped_pendulum_step verification failed");
		$finish;
	end
endmodule

[filelist.f]
+incdir+rtl
rtl/dps_pkg.sv
rtl/damped_pendulum_step.sv
rtl/dps_checker.sv
verif/tb_top.sv
